### hw/rtl/bat_pkg.sv
package bat_pkg;

    // Fixed widths of the port fields
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int POS_OUT_W = 10;

    // Threshold after reset, about 0.97 of full scale
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd63569;

    // One sample beat held between the input register and the detector core
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_beat;

endpackage

### hw/rtl/bat_in_stage.sv
module bat_in_stage import bat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_advance,
    output logic                o_in_stall,
    output t_beat               o_beat
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                w_load;

    // Load when empty or when the held beat moves on this cycle
    assign w_load     = !r_valid || i_advance;
    assign o_in_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_beat.valid  = r_valid;
    assign o_beat.sample = r_sample;

endmodule

### hw/rtl/bat_core.sv
module bat_core import bat_pkg::*; #(
    parameter int BLOCK_LEN   = 50,
    parameter int WINDOW_LEN  = 1000,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_beat                i_beat,
    input  logic                 i_out_stall,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output logic                 o_level,
    output logic [POS_OUT_W-1:0] o_crossing_position,
    output logic                 o_changed
);

    localparam int EB    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int SUM_W = EB + CNT_W;
    localparam int POS_W = $clog2(WINDOW_LEN + 1);

    logic [SUM_W-1:0] r_limit, n_limit;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_pos;
    logic             r_level;
    logic [POS_W-1:0] r_cross;
    logic             r_out_valid;
    logic             r_changed;

    logic             w_fire;
    logic             w_wrap;
    logic [SUM_W-1:0] w_base_sum;
    logic [CNT_W-1:0] w_base_cnt;
    logic [POS_W-1:0] w_pos_next;
    logic [SUM_W-1:0] w_sum_new;
    logic             w_block_end;
    logic             w_high;
    logic             w_flip;
    logic [POS_W+POS_OUT_W-1:0] w_cross_ext;

    assign o_advance = !(r_out_valid && i_out_stall);
    assign w_fire    = i_beat.valid && o_advance;

    // Limit is threshold times block length, formed once per register write
    assign n_limit = SUM_W'(i_cfg_data[EB-1:0]) * SUM_W'(BLOCK_LEN);

    // Restart the block at the window wrap
    assign w_wrap      = (r_pos == POS_W'(WINDOW_LEN));
    assign w_base_sum  = w_wrap ? '0 : r_sum;
    assign w_base_cnt  = w_wrap ? '0 : r_cnt;
    assign w_pos_next  = w_wrap ? POS_W'(1) : r_pos + POS_W'(1);
    assign w_sum_new   = w_base_sum + SUM_W'(i_beat.sample[EB-1:0]);
    assign w_block_end = (w_base_cnt == CNT_W'(BLOCK_LEN - 1));
    assign w_high      = (w_sum_new >= r_limit);
    assign w_flip      = w_block_end && (w_high != r_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= SUM_W'(THRESHOLD_RESET[EB-1:0]) * SUM_W'(BLOCK_LEN);
        end else if (i_cfg_we) begin
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_level     <= 1'b0;
            r_cross     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_beat.valid;
            if (i_beat.valid) begin
                r_pos <= w_pos_next;
                if (w_block_end) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_sum_new;
                    r_cnt <= w_base_cnt + CNT_W'(1);
                end
                if (w_flip) begin
                    r_level <= w_high;
                    r_cross <= w_pos_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_changed <= w_flip;
        end
    end

    // Show the low bits of the position, zero-extended when narrower
    assign w_cross_ext = {{POS_OUT_W{1'b0}}, r_cross};

    assign o_out_valid         = r_out_valid;
    assign o_level             = r_level;
    assign o_crossing_position = w_cross_ext[POS_OUT_W-1:0];
    assign o_changed           = r_changed;

endmodule

### hw/rtl/block_average_threshold_detector_top.sv
// Channel   Valid        Stall         Payload
// input     i_in_valid   o_in_stall    i_sample
// output    o_out_valid  i_out_stall   o_level, o_crossing_position, o_changed
// config    i_cfg_we     (none)        i_cfg_data (threshold)
//
// One beat per cycle sustained while the output is not stalled; a sample passes
// the input register, then the result register, with the single add and
// compare between them.
// Reset (i_rst_n low, synchronous) empties both registers, clears sum, count,
// position, level and last crossing, and loads the default threshold.
// A stalled output holds its beat; the input register still takes one more
// beat, then the input stalls until the output moves.
module block_average_threshold_detector_top import bat_pkg::*; #(
    parameter int BLOCK_LEN   = 50,
    parameter int WINDOW_LEN  = 1000,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // sample channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_level,
    output logic [POS_OUT_W-1:0] o_crossing_position,
    output logic                 o_changed
);

    t_beat w_beat;
    logic  w_advance;

    // Hold one incoming beat so the input keeps flowing while a result waits
    bat_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sample   (i_sample),
        .i_advance  (w_advance),
        .o_in_stall (o_in_stall),
        .o_beat     (w_beat)
    );

    // Accumulate the block, compare with the scaled threshold at block end,
    // track level and crossing position, and register the result beat
    bat_core #(
        .BLOCK_LEN   (BLOCK_LEN),
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_beat              (w_beat),
        .i_out_stall         (i_out_stall),
        .o_advance           (w_advance),
        .o_out_valid         (o_out_valid),
        .o_level             (o_level),
        .o_crossing_position (o_crossing_position),
        .o_changed           (o_changed)
    );

endmodule

### hw/rtl/bat_checker.sv
module bat_checker import bat_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [SAMPLE_W-1:0]  i_sample,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_level,
    input logic [POS_OUT_W-1:0] o_crossing_position,
    input logic                 o_changed
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // Level moves only on a result that reports a change
    a_level_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(o_level)) |-> (o_out_valid && o_changed))
        else $error("level moved without a change beat");

    // Crossing position moves only on a result that reports a change
    a_cross_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(o_crossing_position)) |->
            (o_out_valid && o_changed))
        else $error("crossing position moved without a change beat");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_level) && $stable(o_crossing_position)
             && $stable(o_changed)))
        else $error("stalled result beat changed");

endmodule

bind block_average_threshold_detector_top bat_checker u_bat_checker (.*);

### sim/block_average_threshold_detector_top_test.sv
`timescale 1ns / 100ps

module block_average_threshold_detector_top_test;
    import bat_pkg::*;

    // Sizes the block is built with here; the window is a whole number of blocks
    localparam int BLOCK_LEN    = 50;
    localparam int WINDOW_LEN   = 1000;
    localparam int SAMPLE_BITS  = 16;
    localparam int TOTAL_ITEMS  = 1550;
    localparam int HOLD_CYCLES  = 300;  // long output hold-off that backs up the input
    localparam int DRAIN_CYCLES = 8;    // margin after the input and result registers drain

    // One result beat as the detector should produce it
    typedef struct packed {
        logic                 level;
        logic [POS_OUT_W-1:0] position;
        logic                 changed;
    } t_result;

    // Shape of the samples within one block of BLOCK_LEN beats
    typedef enum logic [2:0] {
        BLK_EXACT,       // every sample equals the threshold: sum lands on the limit
        BLK_JUST_BELOW,  // as above, last sample one lower: sum one short of the limit
        BLK_ABOVE,       // every sample at or above the threshold
        BLK_BELOW,       // every sample below the threshold
        BLK_NOISE,       // full-range random
        BLK_FULL,        // all ones
        BLK_EMPTY        // all zeros
    } t_blk_mode;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_sample   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_level;
    logic [POS_OUT_W-1:0] o_crossing_position;
    logic                 o_changed;

    // Detector state as the predictor tracks it
    logic [CFG_W-1:0]     thr_reg   = THRESHOLD_RESET;
    logic [21:0]          acc_sum   = '0;
    logic [5:0]           acc_count = '0;
    logic [9:0]           win_pos   = '0;
    logic                 det_level = 1'b0;
    logic [9:0]           cross_pos = '0;

    t_result              expected_results[$];
    t_result              result_head;

    // Stimulus control shared by the test tasks, the sender and the receiver
    t_blk_mode            blk_mode      = BLK_NOISE;
    bit                   force_flip    = 1'b0;
    bit                   sender_quiet  = 1'b0;
    bit                   hold_request  = 1'b0;
    int                   hold_left     = 0;
    int                   run_left      = 0;
    int                   stall_pct     = 0;

    int unsigned          items_sent    = 0;
    int unsigned          results_seen  = 0;
    int unsigned          level_changes = 0;
    int unsigned          thr_writes    = 0;
    int unsigned          holds_done    = 0;
    int unsigned          mismatches    = 0;

    block_average_threshold_detector_top #(
        .BLOCK_LEN   (BLOCK_LEN),
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample            (i_sample),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_level             (o_level),
        .o_crossing_position (o_crossing_position),
        .o_changed           (o_changed)
    );

    always #2 i_clk = ~i_clk;

    // Advance the detector by one accepted sample and return the result beat it
    // must produce. The block sum is compared with threshold times BLOCK_LEN so
    // no division is needed.
    function automatic t_result predict_detector(input logic [SAMPLE_W-1:0] s);
        t_result     r;
        logic [22:0] limit;
        r.changed = 1'b0;
        // Wrap the window back to position one and drop any partial block
        if (win_pos >= WINDOW_LEN) begin
            win_pos   = 10'd1;
            acc_sum   = '0;
            acc_count = '0;
        end else begin
            win_pos = win_pos + 10'd1;
        end
        acc_sum   = acc_sum + 22'(s);
        acc_count = acc_count + 6'd1;
        if (acc_count >= BLOCK_LEN) begin
            limit = 23'(thr_reg) * 23'(BLOCK_LEN);
            if ((23'(acc_sum) >= limit) != det_level) begin
                det_level = ~det_level;
                cross_pos = win_pos;
                r.changed = 1'b1;
            end
            acc_sum   = '0;
            acc_count = '0;
        end
        r.level    = det_level;
        r.position = cross_pos;
        return r;
    endfunction

    // Pick the next sample. At each block start choose a block shape; lean
    // toward shapes that flip the level so crossings happen often, and hit the
    // exact limit and one below it.
    function automatic logic [SAMPLE_W-1:0] next_sample();
        logic [SAMPLE_W-1:0] s;
        if (acc_count == 0) begin
            if (force_flip || $urandom_range(99) < 50) begin
                if (det_level)
                    blk_mode = $urandom_range(1) ? BLK_BELOW : BLK_JUST_BELOW;
                else
                    blk_mode = $urandom_range(1) ? BLK_ABOVE : BLK_EXACT;
            end else begin
                blk_mode = t_blk_mode'($urandom_range(6));
            end
        end
        case (blk_mode)
            BLK_EXACT:      s = thr_reg;
            BLK_JUST_BELOW: s = (acc_count == BLOCK_LEN - 1 && thr_reg != 0) ? thr_reg - 1'b1
                                                                              : thr_reg;
            BLK_ABOVE:      s = SAMPLE_W'($urandom_range(16'hFFFF, thr_reg));
            BLK_BELOW:      s = (thr_reg == 0) ? '0 : SAMPLE_W'($urandom_range(thr_reg - 1, 0));
            BLK_FULL:       s = '1;
            BLK_EMPTY:      s = '0;
            default:        s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(8, 4);
        return $urandom_range(40, 10);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH at result %0d: %s expected %0d got %0d",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    // Offer one sample beat and hold it until accepted, then predict its result.
    // Valid stays high after acceptance so back-to-back beats need no extra step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_detector(s));
        items_sent++;
    endtask

    task automatic run_random_items(input int n);
        repeat (n) send_sample(next_sample());
    endtask

    // Drop valid and wait until every predicted result has been seen
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the threshold while the detector is idle
    task automatic write_threshold(input logic [CFG_W-1:0] value);
        wait_for_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        thr_reg = value;
        thr_writes++;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_W'($urandom);
    endtask

    // Short fixed set at the reset threshold: field extremes and single-bit patterns
    task automatic test_directed_extremes();
        logic [SAMPLE_W-1:0] pats[$];
        pats = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00};
        for (int b = 0; b < SAMPLE_W; b += 2)
            pats.push_back(16'h0001 << b);
        foreach (pats[k]) begin
            if (k < 25) send_sample(pats[k]);
        end
    endtask

    // Walk the threshold through its extremes and a few values between; some
    // phases run without sender gaps
    task automatic test_threshold_sweep();
        logic [CFG_W-1:0] thr_list[6];
        thr_list = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, CFG_W'($urandom)};
        foreach (thr_list[k]) begin
            write_threshold(thr_list[k]);
            sender_quiet = (k % 3 == 0);
            run_random_items(100);
        end
        sender_quiet = 1'b0;
    endtask

    // Hold the output for a long stretch while samples keep coming, so the
    // input register fills and the block stalls its input
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        sender_quiet = 1'b1;
        run_random_items(100);
        sender_quiet = 1'b0;
    endtask

    // Flip the level on every block across the end of the window, so crossings
    // are recorded at the last position and again right after the wrap
    task automatic test_window_wrap();
        write_threshold(CFG_W'($urandom_range(16'hC000, 16'h4000)));
        force_flip = 1'b1;
        do send_sample(next_sample()); while (win_pos != WINDOW_LEN);
        do send_sample(next_sample()); while (win_pos != 100);
        force_flip = 1'b0;
    endtask

    // Fill up the rest of the run, first at the reset threshold, then a random one
    task automatic test_random_tail();
        write_threshold(THRESHOLD_RESET);
        run_random_items(200);
        write_threshold(CFG_W'($urandom));
        while (items_sent < TOTAL_ITEMS) send_sample(next_sample());
    endtask

    // Receiver: random stall runs of varying density, rare long stalls, and the
    // one requested long hold counted here in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            holds_done++;
            i_out_stall <= 1'b1;
        end else begin
            if (run_left == 0) begin
                if ($urandom_range(99) < 3) begin
                    run_left  = $urandom_range(60, 20);
                    stall_pct = 100;
                end else begin
                    run_left = $urandom_range(30, 1);
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
            end else begin
                run_left--;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, level", 0, o_level);
            end else begin
                result_head = expected_results.pop_front();
                if (result_head.changed) level_changes++;
                if (o_level !== result_head.level)
                    report_mismatch("level", result_head.level, o_level);
                if (o_crossing_position !== result_head.position)
                    report_mismatch("crossing_position", result_head.position,
                                    o_crossing_position);
                if (o_changed !== result_head.changed)
                    report_mismatch("changed", result_head.changed, o_changed);
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_threshold_sweep();
        test_output_backpressure();
        test_window_wrap();
        test_random_tail();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sample beats and %0d result beats with %0d level changes,",
                 items_sent, results_seen, level_changes);
        $display("%0d threshold writes including both extremes, %0d long output hold(s).",
                 thr_writes, holds_done);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still pending", expected_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
